// ----- hw/rtl/aaci_pkg.sv -----
// ----------------------------------------------------------------------------
// aaci_pkg
// Shared constants and types for the alpha-aware colour interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aaci_pkg;

    // Default component width; components mean value / (2^bits - 1).
    localparam int COMPONENT_BITS_DEF = 8;

    // Position is an unsigned fraction of 256.
    localparam int POS_BITS   = 9;
    localparam int FRAC_BITS  = 8;
    localparam int POS_ONE    = 1 << FRAC_BITS;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    // Control carried alongside each pipeline slot.
    typedef struct packed {
        logic valid;
        logic use_div;
    } t_ctl;

endpackage : aaci_pkg

`default_nettype wire

// ----- hw/rtl/aaci_front.sv -----
// ----------------------------------------------------------------------------
// aaci_front
// Three-stage front end: alpha weights, weighted products, dividend and
// aligned divisor for the division chain, plus the results of the simple cases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aaci_front #(
    parameter int COMPONENT_BITS = aaci_pkg::COMPONENT_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [2:0][COMPONENT_BITS-1:0]             i_c1,
    input  logic [COMPONENT_BITS-1:0]                  i_a1,
    input  logic [2:0][COMPONENT_BITS-1:0]             i_c2,
    input  logic [COMPONENT_BITS-1:0]                  i_a2,
    input  logic [aaci_pkg::POS_BITS-1:0]              i_pos,
    input  logic                                       i_en,
    output aaci_pkg::t_ctl                             o_ctl,
    output logic [2:0][2*COMPONENT_BITS+8:0]           o_rem,
    output logic [2*COMPONENT_BITS+8:0]                o_div,
    output logic [3:0][COMPONENT_BITS-1:0]             o_side
);
    import aaci_pkg::*;

    localparam int N  = COMPONENT_BITS;
    localparam int PW = N + FRAC_BITS;      // alpha weight, x * a
    localparam int MW = N + POS_BITS;       // raw product of position and component
    localparam int NW = 2 * N + FRAC_BITS;  // weighted colour, x * a * c
    localparam int RW = 2 * N + FRAC_BITS + 1;

    function automatic logic [PW-1:0] mul_pos(logic [POS_BITS-1:0] p, logic [N-1:0] c);
        logic [MW-1:0] prod;
        prod = MW'(p) * MW'(c);
        return prod[PW-1:0];
    endfunction

    // Stage A: weights and lerp products.
    logic                 r_a_valid;
    logic [PW-1:0]        r_a_p1, r_a_p2;
    logic [2:0][PW-1:0]   r_a_l1, r_a_l2;
    logic [2:0][N-1:0]    r_a_c1, r_a_c2;
    logic [N-1:0]         r_a_a1;
    logic                 r_a_eq, r_a_a1z, r_a_a2z;

    // Stage B: alpha sum, weighted colours, simple-case colours.
    logic                 r_b_valid;
    logic [PW-1:0]        r_b_s;
    logic [2:0][NW-1:0]   r_b_n1, r_b_n2;
    logic [2:0][N-1:0]    r_b_alt;
    logic [N-1:0]         r_b_a1;
    logic                 r_b_eq, r_b_use_div;

    // Stage C: dividend, aligned divisor, alpha.
    t_ctl                 r_c_ctl;
    logic [2:0][RW-1:0]   r_c_rem;
    logic [RW-1:0]        r_c_div;
    logic [3:0][N-1:0]    r_c_side;

    logic en_a, en_b, en_c;

    assign en_c    = !r_c_ctl.valid || i_en;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;

    logic [POS_BITS-1:0]  x, w;
    logic [2:0][PW-1:0]   n_a_l1, n_a_l2;

    always_comb begin
        // Anything at or above one saturates to one.
        x = i_pos[POS_BITS-1] ? POS_BITS'(POS_ONE) : i_pos;
        w = POS_BITS'(POS_ONE) - x;
        for (int i = 0; i < 3; i++) begin
            n_a_l1[i] = mul_pos(w, i_c1[i]);
            n_a_l2[i] = mul_pos(x, i_c2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_valid;
        end
        if (en_a) begin
            r_a_p1  <= mul_pos(w, i_a1);
            r_a_p2  <= mul_pos(x, i_a2);
            r_a_l1  <= n_a_l1;
            r_a_l2  <= n_a_l2;
            r_a_c1  <= i_c1;
            r_a_c2  <= i_c2;
            r_a_a1  <= i_a1;
            r_a_eq  <= (i_a1 == i_a2);
            r_a_a1z <= (i_a1 == '0);
            r_a_a2z <= (i_a2 == '0);
        end
    end

    logic [2:0][NW-1:0]   n_b_n1, n_b_n2;
    logic [2:0][N-1:0]    n_b_alt;
    logic [PW-1:0]        lerp_sum;

    always_comb begin
        lerp_sum = '0;
        for (int i = 0; i < 3; i++) begin
            n_b_n1[i] = NW'(r_a_p1) * NW'(r_a_c1[i]);
            n_b_n2[i] = NW'(r_a_p2) * NW'(r_a_c2[i]);
            lerp_sum  = r_a_l1[i] + r_a_l2[i] + PW'(ROUND_HALF);
            priority if (r_a_eq) begin
                n_b_alt[i] = lerp_sum[PW-1:FRAC_BITS];
            end else if (r_a_a2z) begin
                n_b_alt[i] = r_a_c1[i];
            end else begin
                n_b_alt[i] = r_a_c2[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
        if (en_b) begin
            r_b_s       <= r_a_p1 + r_a_p2;
            r_b_n1      <= n_b_n1;
            r_b_n2      <= n_b_n2;
            r_b_alt     <= n_b_alt;
            r_b_a1      <= r_a_a1;
            r_b_eq      <= r_a_eq;
            r_b_use_div <= !r_a_eq && !r_a_a1z && !r_a_a2z;
        end
    end

    logic [2:0][RW-1:0]   n_c_rem;
    logic [NW-1:0]        num;
    logic [PW-1:0]        alpha_sum;
    logic [N-1:0]         n_c_alpha;

    always_comb begin
        num = '0;
        for (int i = 0; i < 3; i++) begin
            num        = r_b_n1[i] + r_b_n2[i];
            // Twice the weighted sum plus the divisor rounds the quotient to nearest.
            n_c_rem[i] = {num, 1'b0} + RW'(r_b_s);
        end
        // Outside the equal-alpha case the alpha is the rounded weight sum.
        alpha_sum = r_b_s + PW'(ROUND_HALF);
        n_c_alpha = r_b_eq ? r_b_a1 : alpha_sum[PW-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else if (en_c) begin
            r_c_ctl.valid   <= r_b_valid;
            r_c_ctl.use_div <= r_b_use_div;
        end
        if (en_c) begin
            r_c_rem  <= n_c_rem;
            // Divisor 2*S, aligned to the top quotient bit.
            r_c_div  <= RW'(r_b_s) << N;
            r_c_side <= {n_c_alpha, r_b_alt[2], r_b_alt[1], r_b_alt[0]};
        end
    end

    assign o_ctl  = r_c_ctl;
    assign o_rem  = r_c_rem;
    assign o_div  = r_c_div;
    assign o_side = r_c_side;

endmodule : aaci_front

`default_nettype wire

// ----- hw/rtl/aaci_div_cell.sv -----
// ----------------------------------------------------------------------------
// aaci_div_cell
// One restoring-division step for the three colour lanes: resolves one
// quotient bit per lane and hands the remainder on with the divisor halved.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aaci_div_cell #(
    parameter int COMPONENT_BITS = aaci_pkg::COMPONENT_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  aaci_pkg::t_ctl                             i_ctl,
    input  logic [2:0][2*COMPONENT_BITS+8:0]           i_rem,
    input  logic [2*COMPONENT_BITS+8:0]                i_div,
    input  logic [2:0][COMPONENT_BITS-1:0]             i_quo,
    input  logic [3:0][COMPONENT_BITS-1:0]             i_side,
    output logic                                       o_en,
    input  logic                                       i_en,
    output aaci_pkg::t_ctl                             o_ctl,
    output logic [2:0][2*COMPONENT_BITS+8:0]           o_rem,
    output logic [2*COMPONENT_BITS+8:0]                o_div,
    output logic [2:0][COMPONENT_BITS-1:0]             o_quo,
    output logic [3:0][COMPONENT_BITS-1:0]             o_side
);
    import aaci_pkg::*;

    localparam int N  = COMPONENT_BITS;
    localparam int RW = 2 * N + FRAC_BITS + 1;

    t_ctl                 r_ctl;
    logic [2:0][RW-1:0]   r_rem;
    logic [RW-1:0]        r_div;
    logic [2:0][N-1:0]    r_quo;
    logic [3:0][N-1:0]    r_side;

    logic [2:0][RW-1:0]   n_rem;
    logic [2:0][N-1:0]    n_quo;

    assign o_en = !r_ctl.valid || i_en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_rem[i] >= i_div) begin
                n_rem[i] = i_rem[i] - i_div;
                n_quo[i] = {i_quo[i][N-2:0], 1'b1};
            end else begin
                n_rem[i] = i_rem[i];
                n_quo[i] = {i_quo[i][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_en) begin
            r_ctl <= i_ctl;
        end
        if (o_en) begin
            r_rem  <= n_rem;
            r_div  <= i_div >> 1;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_div  = r_div;
    assign o_quo  = r_quo;
    assign o_side = r_side;

endmodule : aaci_div_cell

`default_nettype wire

// ----- hw/rtl/aaci_out_stage.sv -----
// ----------------------------------------------------------------------------
// aaci_out_stage
// Output register: picks the divided colour or the simple-case colour and
// holds the result until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aaci_out_stage #(
    parameter int COMPONENT_BITS = aaci_pkg::COMPONENT_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  aaci_pkg::t_ctl                             i_ctl,
    input  logic [2:0][COMPONENT_BITS-1:0]             i_quo,
    input  logic [3:0][COMPONENT_BITS-1:0]             i_side,
    output logic                                       o_en,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic [3:0][COMPONENT_BITS-1:0]             o_rgba
);
    import aaci_pkg::*;

    localparam int N = COMPONENT_BITS;

    logic                 r_valid;
    logic [3:0][N-1:0]    r_rgba;
    logic [3:0][N-1:0]    n_rgba;

    assign o_en = !r_valid || i_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // The quotient never exceeds full scale, so no clamp is needed.
            n_rgba[i] = i_ctl.use_div ? i_quo[i] : i_side[i];
        end
        n_rgba[3] = i_side[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_ctl.valid;
        end
        if (o_en) begin
            r_rgba <= n_rgba;
        end
    end

    assign o_valid = r_valid;
    assign o_rgba  = r_rgba;

endmodule : aaci_out_stage

`default_nettype wire

// ----- hw/rtl/alpha_aware_colour_interpolator.sv -----
// ----------------------------------------------------------------------------
// alpha_aware_colour_interpolator
// Blends two non-premultiplied RGBA colours at a position x/256 so that each
// colour pulls the result in proportion to its opacity. The block takes one
// transaction per clock unless a stalled output has filled the pipeline, and
// passes each through three front-end stages forming the alpha weights and
// weighted sums, a chain of COMPONENT_BITS division cells resolving one
// quotient bit per cell for all three colour channels, and a final register
// holding the result. Each stage moves up whenever the stage after it is
// empty or moving, so a stalled output only holds back the items queued
// behind it and empty slots are filled while the output waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alpha_aware_colour_interpolator #(
    parameter int COMPONENT_BITS = aaci_pkg::COMPONENT_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_s_axis_tvalid,
    output logic                                              o_s_axis_tready,
    // first_red, first_green, first_blue, first_alpha, second_red,
    // second_green, second_blue, second_alpha, position; zero padded
    input  logic [((8*COMPONENT_BITS+aaci_pkg::POS_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                              o_m_axis_tvalid,
    input  logic                                              i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha; zero padded
    output logic [((4*COMPONENT_BITS+7)/8)*8-1:0]             o_m_axis_tdata
);
    import aaci_pkg::*;

    localparam int N     = COMPONENT_BITS;
    localparam int RW    = 2 * N + FRAC_BITS + 1;
    localparam int OUT_W = ((4 * N + 7) / 8) * 8;

    logic [2:0][N-1:0]        c1, c2;
    logic [N-1:0]             a1, a2;
    logic [POS_BITS-1:0]      pos;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c1[i] = i_s_axis_tdata[i*N +: N];
            c2[i] = i_s_axis_tdata[(4+i)*N +: N];
        end
        a1  = i_s_axis_tdata[3*N +: N];
        a2  = i_s_axis_tdata[7*N +: N];
        pos = i_s_axis_tdata[8*N +: POS_BITS];
    end

    t_ctl                     ctl_w  [N+1];
    logic [2:0][RW-1:0]       rem_w  [N+1];
    logic [RW-1:0]            div_w  [N+1];
    logic [2:0][N-1:0]        quo_w  [N+1];
    logic [3:0][N-1:0]        side_w [N+1];
    logic                     en_w   [N+1];
    logic [3:0][N-1:0]        rgba;

    assign quo_w[0] = '0;

    aaci_front #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_c1    (c1),
        .i_a1    (a1),
        .i_c2    (c2),
        .i_a2    (a2),
        .i_pos   (pos),
        .i_en    (en_w[0]),
        .o_ctl   (ctl_w[0]),
        .o_rem   (rem_w[0]),
        .o_div   (div_w[0]),
        .o_side  (side_w[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cell
        aaci_div_cell #(
            .COMPONENT_BITS (COMPONENT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_w[k]),
            .i_rem   (rem_w[k]),
            .i_div   (div_w[k]),
            .i_quo   (quo_w[k]),
            .i_side  (side_w[k]),
            .o_en    (en_w[k]),
            .i_en    (en_w[k+1]),
            .o_ctl   (ctl_w[k+1]),
            .o_rem   (rem_w[k+1]),
            .o_div   (div_w[k+1]),
            .o_quo   (quo_w[k+1]),
            .o_side  (side_w[k+1])
        );
    end

    aaci_out_stage #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_w[N]),
        .i_quo   (quo_w[N]),
        .i_side  (side_w[N]),
        .o_en    (en_w[N]),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_rgba  (rgba)
    );

    assign o_m_axis_tdata = OUT_W'(rgba);

endmodule : alpha_aware_colour_interpolator

`default_nettype wire
